>>> hdl/kese_pkg.sv
// Package for the key to escape sequence encoder.
// Holds the payload and descriptor types, the key codes, the byte codes and the key tables.
// No dependencies.
`default_nettype none

package kese_pkg;

   // Input transaction payload
   typedef struct packed {
      logic [4:0] key_code;
      logic       ctrl_held;
      logic       shift_held;
      logic       alt_held;
   } kese_req_type;

   // Result transaction payload
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_byte;
   } kese_rsp_type;

   localparam int SEQ_MAX = 7;

   // A fully built byte sequence for one key. seq_len is 1..SEQ_MAX.
   typedef struct packed {
      logic [SEQ_MAX-1:0][7:0] seq_bytes;
      logic [2:0]              seq_len;
   } kese_seq_type;

   // Key codes
   localparam logic [4:0] KEY_ENTER  = 5'd0;
   localparam logic [4:0] KEY_BKSP   = 5'd1;
   localparam logic [4:0] KEY_TAB    = 5'd2;
   localparam logic [4:0] KEY_ESCAPE = 5'd3;
   localparam logic [4:0] KEY_UP     = 5'd4;
   localparam logic [4:0] KEY_DOWN   = 5'd5;
   localparam logic [4:0] KEY_RIGHT  = 5'd6;
   localparam logic [4:0] KEY_LEFT   = 5'd7;
   localparam logic [4:0] KEY_HOME   = 5'd8;
   localparam logic [4:0] KEY_END    = 5'd9;
   localparam logic [4:0] KEY_INSERT = 5'd10;
   localparam logic [4:0] KEY_DELETE = 5'd11;
   localparam logic [4:0] KEY_PGUP   = 5'd12;
   localparam logic [4:0] KEY_PGDN   = 5'd13;
   localparam logic [4:0] KEY_F1     = 5'd14;
   localparam logic [4:0] KEY_F2     = 5'd15;
   localparam logic [4:0] KEY_F3     = 5'd16;
   localparam logic [4:0] KEY_F4     = 5'd17;
   localparam logic [4:0] KEY_F5     = 5'd18;
   localparam logic [4:0] KEY_F6     = 5'd19;
   localparam logic [4:0] KEY_F7     = 5'd20;
   localparam logic [4:0] KEY_F8     = 5'd21;
   localparam logic [4:0] KEY_F9     = 5'd22;
   localparam logic [4:0] KEY_F10    = 5'd23;
   localparam logic [4:0] KEY_F11    = 5'd24;
   localparam logic [4:0] KEY_F12    = 5'd25;

   // Byte codes
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
   localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
   localparam logic [7:0] CH_TILDE = 8'h7E;  // '~'
   localparam logic [7:0] CH_O     = 8'h4F;  // 'O'
   localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CH_ONE   = 8'h31;  // '1'

   // Final letter of the short and modified cursor / F1-F4 forms
   function automatic logic [7:0] key_final(input logic [4:0] key);
      logic [7:0] c;
      begin
         unique case (key)
            KEY_UP:    c = 8'h41;  // 'A'
            KEY_DOWN:  c = 8'h42;  // 'B'
            KEY_RIGHT: c = 8'h43;  // 'C'
            KEY_LEFT:  c = 8'h44;  // 'D'
            KEY_HOME:  c = 8'h48;  // 'H'
            KEY_END:   c = 8'h46;  // 'F'
            KEY_F1:    c = 8'h50;  // 'P'
            KEY_F2:    c = 8'h51;  // 'Q'
            KEY_F3:    c = 8'h52;  // 'R'
            KEY_F4:    c = 8'h53;  // 'S'
            default:   c = 8'h00;
         endcase
         return c;
      end
   endfunction

   // Decimal number of the tilde form as two digit values; tens is zero for one digit
   function automatic logic [7:0] key_num_bcd(input logic [4:0] key);
      logic [7:0] v;
      begin
         unique case (key)
            KEY_INSERT: v = 8'h02;
            KEY_DELETE: v = 8'h03;
            KEY_PGUP:   v = 8'h05;
            KEY_PGDN:   v = 8'h06;
            KEY_F5:     v = 8'h15;
            KEY_F6:     v = 8'h17;
            KEY_F7:     v = 8'h18;
            KEY_F8:     v = 8'h19;
            KEY_F9:     v = 8'h20;
            KEY_F10:    v = 8'h21;
            KEY_F11:    v = 8'h23;
            KEY_F12:    v = 8'h24;
            default:    v = 8'h00;
         endcase
         return v;
      end
   endfunction

endpackage

`default_nettype wire

>>> hdl/kese_front.sv
// Front end of the key encoder: accepts a key transaction and builds its full byte sequence.
// Depends on kese_pkg.
`default_nettype none

module kese_front import kese_pkg::*; (
   input  wire logic         req_valid,
   input  wire kese_req_type req_data,
   input  wire logic         q_full,
   output logic              req_ready,
   output logic              q_push,
   output kese_seq_type      q_data
);

   logic [3:0] mod_num;
   logic [7:0] mod_char;
   logic [7:0] num_bcd;
   logic [7:0] fin_char;
   logic [2:0] pos;
   logic       key_ok;

   assign req_ready = ~q_full;
   assign key_ok    = (req_data.key_code <= KEY_F12);
   // drop unused key codes: they produce no bytes
   assign q_push    = req_valid & ~q_full & key_ok;

   always_comb begin
      mod_num  = 4'd1 + {3'd0, req_data.shift_held} + {2'd0, req_data.alt_held, 1'b0}
               + {1'b0, req_data.ctrl_held, 2'b00};
      mod_char = CH_ZERO + {4'd0, mod_num};
      num_bcd  = key_num_bcd(req_data.key_code);
      fin_char = key_final(req_data.key_code);
      pos      = 3'd0;
      q_data   = '0;
      q_data.seq_bytes[0] = CH_ESC;
      q_data.seq_len      = 3'd1;
      case (req_data.key_code) inside
         KEY_ENTER: q_data.seq_bytes[0] = CH_CR;
         KEY_BKSP:  q_data.seq_bytes[0] = req_data.ctrl_held ? CH_BS : CH_DEL;
         KEY_TAB:   q_data.seq_bytes[0] = CH_TAB;
         KEY_ESCAPE: q_data.seq_bytes[0] = CH_ESC;
         [KEY_UP:KEY_END], [KEY_F1:KEY_F4]: begin
            if (mod_num == 4'd1) begin
               q_data.seq_bytes[1] = (req_data.key_code >= KEY_F1) ? CH_O : CH_LBRK;
               q_data.seq_bytes[2] = fin_char;
               q_data.seq_len      = 3'd3;
            end else begin
               q_data.seq_bytes[1] = CH_LBRK;
               q_data.seq_bytes[2] = CH_ONE;
               q_data.seq_bytes[3] = CH_SEMI;
               q_data.seq_bytes[4] = mod_char;
               q_data.seq_bytes[5] = fin_char;
               q_data.seq_len      = 3'd6;
            end
         end
         [KEY_INSERT:KEY_PGDN], [KEY_F5:KEY_F12]: begin
            q_data.seq_bytes[1] = CH_LBRK;
            if (num_bcd[7:4] != 4'd0) begin
               q_data.seq_bytes[2] = CH_ZERO + {4'd0, num_bcd[7:4]};
               q_data.seq_bytes[3] = CH_ZERO + {4'd0, num_bcd[3:0]};
               pos = 3'd4;
            end else begin
               q_data.seq_bytes[2] = CH_ZERO + {4'd0, num_bcd[3:0]};
               pos = 3'd3;
            end
            if (mod_num != 4'd1) begin
               q_data.seq_bytes[pos]        = CH_SEMI;
               q_data.seq_bytes[pos + 3'd1] = mod_char;
               q_data.seq_bytes[pos + 3'd2] = CH_TILDE;
               q_data.seq_len               = pos + 3'd3;
            end else begin
               q_data.seq_bytes[pos] = CH_TILDE;
               q_data.seq_len        = pos + 3'd1;
            end
         end
         default: q_data.seq_len = 3'd1;
      endcase
   end

endmodule

`default_nettype wire

>>> hdl/kese_queue.sv
// Short descriptor queue between the front and back ends of the key encoder.
// Depends on kese_pkg.
`default_nettype none

module kese_queue import kese_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire kese_seq_type push_data,
   input  wire logic         pop,
   output logic              full,
   output logic              head_valid,
   output kese_seq_type      head_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   kese_seq_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> hdl/kese_back.sv
// Back end of the key encoder: walks the head sequence and emits one byte per transaction.
// Depends on kese_pkg.
`default_nettype none

module kese_back import kese_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         head_valid,
   input  wire kese_seq_type head_data,
   output logic              pop,
   input  wire logic         rsp_ready,
   output logic              rsp_valid,
   output kese_rsp_type      rsp_data
);

   logic [2:0]   idx_ff, idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   kese_rsp_type rsp_data_ff, rsp_data_in;
   logic         load, is_last;

   assign load    = head_valid & (~rsp_valid_ff | rsp_ready);
   assign is_last = (idx_ff == head_data.seq_len - 3'd1);
   assign pop     = load & is_last;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in          = 1'b1;
         rsp_data_in.out_byte  = head_data.seq_bytes[idx_ff];
         rsp_data_in.last_byte = is_last;
         idx_in                = is_last ? 3'd0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> hdl/key_to_escape_sequence_encoder.sv
// Top level of the key to escape sequence encoder.
// Depends on kese_pkg, kese_front, kese_queue and kese_back.
//
//   Channel  Ports                          Dir  Payload
//   req      req_valid/req_ready/req_data   in   kese_req_type: key code, ctrl, shift, alt
//   rsp      rsp_valid/rsp_ready/rsp_data   out  kese_rsp_type: one byte, last-byte flag
//
// A key transaction with a code up to F12 yields 1 to 7 byte transactions, one per cycle
// while rsp_ready stays high; the single output register holds each byte until it is taken.
// The front builds the whole sequence in the cycle of acceptance and pushes it into a
// QUEUE_DEPTH-entry queue; req_ready drops only while that queue is full.
// Key codes above F12 are accepted and dropped without any byte.
// Reset clears the queue pointers and count, the byte index and the output valid.
// A stall on rsp holds the current byte; the front keeps taking keys until the queue fills.
`default_nettype none

module key_to_escape_sequence_encoder import kese_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire kese_req_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output kese_rsp_type      rsp_data
);

   logic         q_push, q_full, q_pop, q_head_valid;
   kese_seq_type q_push_data, q_head_data;

   // Classify the key and build its sequence
   kese_front u_front (
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .req_ready (req_ready),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // Hold built sequences until the back end is free
   kese_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_push_data),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head_data)
   );

   // Emit the bytes of the head sequence, advance on each accepted byte
   kese_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
